// ===== rtl/core/kol_pkg.sv =====
// ----------------------------------------------------------------------------
// kol_pkg: shared types and codes for the keyword and operator lexer
// Record layout, queue entry, token kinds, error codes and queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package kol_pkg;

  // record types
  localparam logic [1:0] R_LEX = 2'd0;
  localparam logic [1:0] R_TOK = 2'd1;
  localparam logic [1:0] R_ERR = 2'd2;

  // token kinds
  localparam logic [5:0] K_NUM     = 6'd0;
  localparam logic [5:0] K_ID      = 6'd1;
  localparam logic [5:0] K_IF      = 6'd2;
  localparam logic [5:0] K_ELSE    = 6'd3;
  localparam logic [5:0] K_WHILE   = 6'd4;
  localparam logic [5:0] K_DO      = 6'd5;
  localparam logic [5:0] K_BREAK   = 6'd6;
  localparam logic [5:0] K_PRINT   = 6'd7;
  localparam logic [5:0] K_TRUE    = 6'd8;
  localparam logic [5:0] K_FALSE   = 6'd9;
  localparam logic [5:0] K_INT     = 6'd10;
  localparam logic [5:0] K_BOOLEAN = 6'd11;
  localparam logic [5:0] K_LSB     = 6'd12;
  localparam logic [5:0] K_RSB     = 6'd13;
  localparam logic [5:0] K_LBRACE  = 6'd14;
  localparam logic [5:0] K_RBRACE  = 6'd15;
  localparam logic [5:0] K_LPAREN  = 6'd16;
  localparam logic [5:0] K_RPAREN  = 6'd17;
  localparam logic [5:0] K_EQEQ    = 6'd18;
  localparam logic [5:0] K_ASSIGN  = 6'd19;
  localparam logic [5:0] K_NE      = 6'd20;
  localparam logic [5:0] K_NOT     = 6'd21;
  localparam logic [5:0] K_GE      = 6'd22;
  localparam logic [5:0] K_GT      = 6'd23;
  localparam logic [5:0] K_LE      = 6'd24;
  localparam logic [5:0] K_LT      = 6'd25;
  localparam logic [5:0] K_ANDAND  = 6'd26;
  localparam logic [5:0] K_OROR    = 6'd27;
  localparam logic [5:0] K_PLUS    = 6'd28;
  localparam logic [5:0] K_MINUS   = 6'd29;
  localparam logic [5:0] K_STAR    = 6'd30;
  localparam logic [5:0] K_SLASH   = 6'd31;
  localparam logic [5:0] K_SEMI    = 6'd32;

  // error codes
  localparam logic [1:0] E_UNEXPECTED = 2'd0;
  localparam logic [1:0] E_AMP        = 2'd1;
  localparam logic [1:0] E_BAR        = 2'd2;
  localparam logic [1:0] E_BRACKET    = 2'd3;

  // queue between scanner and output stage
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [1:0] rtype;
    logic [5:0] kind;
    logic [7:0] lex;
    logic [1:0] err;
  } rec_t;

  // one input word's results: one or two records
  typedef struct packed {
    logic two;
    rec_t r0;
    rec_t r1;
  } q_entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/kol_front.sv =====
// ----------------------------------------------------------------------------
// kol_front: character scanner
// Accepts one character word per cycle unless the queue is full, tracks the
// scan state and builds the one or two result records each character causes.
// ----------------------------------------------------------------------------
`default_nettype none

module kol_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,
  input  wire logic              in_tlast,
  input  wire logic              q_full,
  output logic                   q_push,
  output kol_pkg::q_entry_t      q_ent
);
  import kol_pkg::*;

  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_WORD   = 3'd1;
  localparam logic [2:0] M_NUMBER = 3'd2;
  localparam logic [2:0] M_OPER   = 3'd3;
  localparam logic [2:0] M_SIZE   = 3'd4;
  localparam logic [2:0] M_HALT   = 3'd5;

  // pending operator codes
  localparam logic [2:0] P_EQ   = 3'd0;
  localparam logic [2:0] P_BANG = 3'd1;
  localparam logic [2:0] P_GT   = 3'd2;
  localparam logic [2:0] P_LT   = 3'd3;
  localparam logic [2:0] P_AMP  = 3'd4;
  localparam logic [2:0] P_BAR  = 3'd5;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] pend;
    logic       has_rec;
    logic       word;
    rec_t       rec;
  } start_t;

  logic [2:0]  mode_r, mode_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic [55:0] wbuf_r, wbuf_nxt;   // first character in the top byte
  logic [3:0]  wlen_r, wlen_nxt;
  logic        sdig_r, sdig_nxt;

  logic        accept;
  logic [7:0]  c;
  logic [2:0]  p;
  logic [5:0]  wkind;
  start_t      sc;
  rec_t        r0, r1;
  logic [1:0]  n;

  function automatic rec_t mk_rec(logic [1:0] t, logic [5:0] k, logic [7:0] l,
                                  logic [1:0] e);
    rec_t r;
    r.rtype = t;
    r.kind  = k;
    r.lex   = l;
    r.err   = e;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] x);
    return (x >= "0") && (x <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] x);
    return ((x >= "a") && (x <= "z")) || ((x >= "A") && (x <= "Z"));
  endfunction

  function automatic logic is_space(logic [7:0] x);
    return (x == " ") || ((x >= 8'd9) && (x <= 8'd13));
  endfunction

  // compare the first tlen buffered characters against a keyword
  function automatic logic kw_match(logic [55:0] b, logic [3:0] len,
                                    logic [55:0] txt, logic [3:0] tlen);
    logic [55:0] sh;
    sh = b >> (8 * (7 - tlen));
    return (len == tlen) && (sh == txt);
  endfunction

  function automatic logic [5:0] word_kind(logic [55:0] b, logic [3:0] len);
    logic [5:0] k;
    k = K_ID;
    if (kw_match(b, len, 56'("if"), 4'd2))      k = K_IF;
    if (kw_match(b, len, 56'("else"), 4'd4))    k = K_ELSE;
    if (kw_match(b, len, 56'("while"), 4'd5))   k = K_WHILE;
    if (kw_match(b, len, 56'("do"), 4'd2))      k = K_DO;
    if (kw_match(b, len, 56'("break"), 4'd5))   k = K_BREAK;
    if (kw_match(b, len, 56'("print"), 4'd5))   k = K_PRINT;
    if (kw_match(b, len, 56'("true"), 4'd4))    k = K_TRUE;
    if (kw_match(b, len, 56'("false"), 4'd5))   k = K_FALSE;
    if (kw_match(b, len, 56'("int"), 4'd3))     k = K_INT;
    if (kw_match(b, len, 56'("boolean"), 4'd7)) k = K_BOOLEAN;
    return k;
  endfunction

  // character seen with no token open
  function automatic start_t start_char(logic [7:0] x);
    start_t s;
    s.mode    = M_IDLE;
    s.pend    = P_EQ;
    s.has_rec = 1'b0;
    s.word    = 1'b0;
    s.rec     = mk_rec(R_TOK, K_NUM, 8'd0, 2'd0);
    if (is_space(x)) begin
      s.has_rec = 1'b0;
    end else if (is_digit(x)) begin
      s.mode    = M_NUMBER;
      s.has_rec = 1'b1;
      s.rec     = mk_rec(R_LEX, K_NUM, x, 2'd0);
    end else if (is_alpha(x)) begin
      s.mode    = M_WORD;
      s.word    = 1'b1;
      s.has_rec = 1'b1;
      s.rec     = mk_rec(R_LEX, K_ID, x, 2'd0);
    end else begin
      s.has_rec = 1'b1;
      case (x)
        "=": begin s.mode = M_OPER; s.pend = P_EQ;   s.has_rec = 1'b0; end
        "!": begin s.mode = M_OPER; s.pend = P_BANG; s.has_rec = 1'b0; end
        ">": begin s.mode = M_OPER; s.pend = P_GT;   s.has_rec = 1'b0; end
        "<": begin s.mode = M_OPER; s.pend = P_LT;   s.has_rec = 1'b0; end
        "&": begin s.mode = M_OPER; s.pend = P_AMP;  s.has_rec = 1'b0; end
        "|": begin s.mode = M_OPER; s.pend = P_BAR;  s.has_rec = 1'b0; end
        "+": s.rec = mk_rec(R_TOK, K_PLUS, 8'd0, 2'd0);
        "-": s.rec = mk_rec(R_TOK, K_MINUS, 8'd0, 2'd0);
        "*": s.rec = mk_rec(R_TOK, K_STAR, 8'd0, 2'd0);
        "/": s.rec = mk_rec(R_TOK, K_SLASH, 8'd0, 2'd0);
        "{": s.rec = mk_rec(R_TOK, K_LBRACE, 8'd0, 2'd0);
        "}": s.rec = mk_rec(R_TOK, K_RBRACE, 8'd0, 2'd0);
        "(": s.rec = mk_rec(R_TOK, K_LPAREN, 8'd0, 2'd0);
        ")": s.rec = mk_rec(R_TOK, K_RPAREN, 8'd0, 2'd0);
        "[": s.rec = mk_rec(R_TOK, K_LSB, 8'd0, 2'd0);
        "]": s.rec = mk_rec(R_TOK, K_RSB, 8'd0, 2'd0);
        ";": s.rec = mk_rec(R_TOK, K_SEMI, 8'd0, 2'd0);
        default: begin
          s.mode = M_HALT;
          s.rec  = mk_rec(R_ERR, K_NUM, 8'd0, E_UNEXPECTED);
        end
      endcase
    end
    return s;
  endfunction

  function automatic logic [7:0] op_second(logic [2:0] q);
    logic [7:0] r;
    case (q)
      P_AMP:   r = "&";
      P_BAR:   r = "|";
      default: r = "=";
    endcase
    return r;
  endfunction

  function automatic logic [5:0] op_pair(logic [2:0] q);
    logic [5:0] r;
    case (q)
      P_EQ:    r = K_EQEQ;
      P_BANG:  r = K_NE;
      P_GT:    r = K_GE;
      P_LT:    r = K_LE;
      P_AMP:   r = K_ANDAND;
      default: r = K_OROR;
    endcase
    return r;
  endfunction

  // lone operator: token, or error for a lone ampersand or bar
  function automatic rec_t op_single(logic [2:0] q);
    rec_t r;
    case (q)
      P_EQ:    r = mk_rec(R_TOK, K_ASSIGN, 8'd0, 2'd0);
      P_BANG:  r = mk_rec(R_TOK, K_NOT, 8'd0, 2'd0);
      P_GT:    r = mk_rec(R_TOK, K_GT, 8'd0, 2'd0);
      P_LT:    r = mk_rec(R_TOK, K_LT, 8'd0, 2'd0);
      P_AMP:   r = mk_rec(R_ERR, K_NUM, 8'd0, E_AMP);
      default: r = mk_rec(R_ERR, K_NUM, 8'd0, E_BAR);
    endcase
    return r;
  endfunction

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign c         = in_tdata;
  assign p         = (pend_r > P_BAR) ? (pend_r - 3'd6) : pend_r;
  assign wkind     = word_kind(wbuf_r, wlen_r);
  assign sc        = start_char(c);

  // next state and records for this character
  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    wbuf_nxt = wbuf_r;
    wlen_nxt = wlen_r;
    sdig_nxt = sdig_r;
    r0       = mk_rec(R_TOK, K_NUM, 8'd0, 2'd0);
    r1       = mk_rec(R_TOK, K_NUM, 8'd0, 2'd0);
    n        = 2'd0;
    if (in_tlast) begin
      case (mode_r)
        M_WORD: begin
          r0 = mk_rec(R_TOK, wkind, 8'd0, 2'd0);
          n  = 2'd1;
        end
        M_NUMBER: begin
          n = 2'd1;
        end
        M_OPER: begin
          r0 = op_single(p);
          n  = 2'd1;
        end
        M_SIZE: begin
          if (sdig_r) begin
            r1 = mk_rec(R_ERR, K_NUM, 8'd0, E_BRACKET);
            n  = 2'd2;
          end else begin
            r0 = mk_rec(R_ERR, K_NUM, 8'd0, E_BRACKET);
            n  = 2'd1;
          end
        end
        default: n = 2'd0;
      endcase
      mode_nxt = M_IDLE;
      pend_nxt = P_EQ;
      wlen_nxt = 4'd0;
      sdig_nxt = 1'b0;
    end else begin
      case (mode_r)
        M_HALT: n = 2'd0;
        M_WORD: begin
          if (is_alpha(c) || is_digit(c) || (c == "_")) begin
            if (wlen_r < 4'd7) wbuf_nxt[55 - 8 * wlen_r[2:0] -: 8] = c;
            if (wlen_r < 4'd8) wlen_nxt = wlen_r + 4'd1;
            r0 = mk_rec(R_LEX, K_ID, c, 2'd0);
            n  = 2'd1;
          end else begin
            r0       = mk_rec(R_TOK, wkind, 8'd0, 2'd0);
            wlen_nxt = 4'd0;
            if ((wkind == K_INT) && (c == "[")) begin
              r1       = mk_rec(R_TOK, K_LSB, 8'd0, 2'd0);
              n        = 2'd2;
              mode_nxt = M_SIZE;
              sdig_nxt = 1'b0;
            end else begin
              r1       = sc.rec;
              n        = sc.has_rec ? 2'd2 : 2'd1;
              mode_nxt = sc.mode;
              if (sc.mode == M_OPER) pend_nxt = sc.pend;
            end
          end
        end
        M_NUMBER: begin
          if (is_digit(c)) begin
            r0 = mk_rec(R_LEX, K_NUM, c, 2'd0);
            n  = 2'd1;
          end else begin
            r1       = sc.rec;
            n        = sc.has_rec ? 2'd2 : 2'd1;
            mode_nxt = sc.mode;
            if (sc.mode == M_OPER) pend_nxt = sc.pend;
            if (sc.word) begin
              wbuf_nxt[55 -: 8] = c;
              wlen_nxt          = 4'd1;
            end
          end
        end
        M_OPER: begin
          if (c == op_second(p)) begin
            r0       = mk_rec(R_TOK, op_pair(p), 8'd0, 2'd0);
            n        = 2'd1;
            mode_nxt = M_IDLE;
          end else if ((p == P_AMP) || (p == P_BAR)) begin
            // lone ampersand or bar halts and swallows this character
            r0       = op_single(p);
            n        = 2'd1;
            mode_nxt = M_HALT;
          end else begin
            r0       = op_single(p);
            r1       = sc.rec;
            n        = sc.has_rec ? 2'd2 : 2'd1;
            mode_nxt = sc.mode;
            if (sc.mode == M_OPER) pend_nxt = sc.pend;
            if (sc.word) begin
              wbuf_nxt[55 -: 8] = c;
              wlen_nxt          = 4'd1;
            end
          end
        end
        M_SIZE: begin
          if (is_digit(c)) begin
            sdig_nxt = 1'b1;
            r0       = mk_rec(R_LEX, K_NUM, c, 2'd0);
            n        = 2'd1;
          end else begin
            sdig_nxt = 1'b0;
            if (c == "]") begin
              r1       = mk_rec(R_TOK, K_RSB, 8'd0, 2'd0);
              mode_nxt = M_IDLE;
            end else begin
              r1       = mk_rec(R_ERR, K_NUM, 8'd0, E_BRACKET);
              mode_nxt = M_HALT;
            end
            if (sdig_r) begin
              n = 2'd2;
            end else begin
              r0 = r1;
              n  = 2'd1;
            end
          end
        end
        default: begin
          r0       = sc.rec;
          n        = sc.has_rec ? 2'd1 : 2'd0;
          mode_nxt = sc.mode;
          if (sc.mode == M_OPER) pend_nxt = sc.pend;
          if (sc.word) begin
            wbuf_nxt[55 -: 8] = c;
            wlen_nxt          = 4'd1;
          end
        end
      endcase
    end
  end

  // queue write
  assign q_push    = accept && (n != 2'd0);
  assign q_ent.two = (n == 2'd2);
  assign q_ent.r0  = r0;
  assign q_ent.r1  = r1;

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pend_r <= P_EQ;
      wlen_r <= 4'd0;
      sdig_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      wlen_r <= wlen_nxt;
      sdig_r <= sdig_nxt;
    end
  end

  // word buffer holds payload only
  always_ff @(posedge clk) begin
    if (accept) wbuf_r <= wbuf_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/kol_fifo.sv =====
// ----------------------------------------------------------------------------
// kol_fifo: result queue
// Short register queue of per-character result entries between the scanner
// and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module kol_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire kol_pkg::q_entry_t push_ent,
  output logic                   full,
  input  wire logic              pop,
  output kol_pkg::q_entry_t      head_ent,
  output logic                   empty
);
  import kol_pkg::*;

  q_entry_t         mem_r [QDEPTH];
  logic [QAW-1:0]   wptr_r, wptr_nxt;
  logic [QAW-1:0]   rptr_r, rptr_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == (QAW + 1)'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_ent = mem_r[rptr_r];

  // pointer and count update
  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_ent;
  end

endmodule

`default_nettype wire

// ===== rtl/core/kol_back.sv =====
// ----------------------------------------------------------------------------
// kol_back: output stage
// Pops queue entries and sends their records from an output register, one
// word per cycle while out_tready is high; marks each entry's final record.
// ----------------------------------------------------------------------------
`default_nettype none

module kol_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire kol_pkg::q_entry_t head_ent,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [15:0]            out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);
  import kol_pkg::*;

  logic  oval_r, oval_nxt;
  logic  olast_r, olast_nxt;
  rec_t  orec_r, orec_nxt;
  logic  sval_r, sval_nxt;
  rec_t  srec_r, srec_nxt;
  logic  adv;

  assign adv   = !oval_r || out_tready;
  assign q_pop = adv && !sval_r && !q_empty;

  // load the output register from the held second record or the queue
  always_comb begin
    oval_nxt  = oval_r;
    olast_nxt = olast_r;
    orec_nxt  = orec_r;
    sval_nxt  = sval_r;
    srec_nxt  = srec_r;
    if (adv) begin
      if (sval_r) begin
        oval_nxt  = 1'b1;
        orec_nxt  = srec_r;
        olast_nxt = 1'b1;
        sval_nxt  = 1'b0;
      end else if (!q_empty) begin
        oval_nxt  = 1'b1;
        orec_nxt  = head_ent.r0;
        olast_nxt = !head_ent.two;
        sval_nxt  = head_ent.two;
        srec_nxt  = head_ent.r1;
      end else begin
        oval_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
      sval_r <= 1'b0;
    end else begin
      oval_r <= oval_nxt;
      sval_r <= sval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    olast_r <= olast_nxt;
    orec_r  <= orec_nxt;
    srec_r  <= srec_nxt;
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = {orec_r.err, orec_r.lex, orec_r.kind};
  assign out_tuser  = orec_r.rtype;
  assign out_tlast  = olast_r;

endmodule

`default_nettype wire

// ===== rtl/core/keyword_operator_lexer.sv =====
// ----------------------------------------------------------------------------
// keyword_operator_lexer: streaming lexer for a small C-like language
// Scanner front end, result queue and output stage.
// ----------------------------------------------------------------------------
// Takes one ASCII character per input word and, with in_tlast high, an
// end-of-input word that flushes any pending token. Each character yields
// zero, one or two output records (lexeme character, token or error); the
// final record of a character has out_tlast set. A character is accepted
// every cycle while the four-entry result queue has room; records leave at
// one per cycle from the output register while out_tready is high, so a
// character that causes two records occupies the output twice and the queue
// absorbs the difference; records pass the queue, then the output register.
// After an error no records appear until the end-of-input word.
`default_nettype none

module keyword_operator_lexer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] ch
  input  wire logic        in_tlast,    // end_of_input
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,   // [5:0] kind, [13:6] lexeme_char, [15:14] error_code
  output logic [1:0]       out_tuser,   // [1:0] record_type
  output logic             out_tlast    // last
);
  import kol_pkg::*;

  q_entry_t push_ent;
  q_entry_t head_ent;
  logic     q_push, q_pop, q_full, q_empty;

  // scanner
  kol_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_ent     (push_ent)
  );

  // result queue
  kol_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (push_ent),
    .full     (q_full),
    .pop      (q_pop),
    .head_ent (head_ent),
    .empty    (q_empty)
  );

  // output stage
  kol_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_ent   (head_ent),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
